// ----- sv/sbt_pkg.sv -----
// sbt_pkg: shared types, constants and helpers for the sub-bass tightener
// used by sbt_mul, sbt_store and sub_bass_tightener
package sbt_pkg;

  localparam int SAMPLE_WIDTH = 24;
  // sample units to q4.28
  localparam int IN_SHIFT = 29 - SAMPLE_WIDTH;
  localparam int ADDR_W = 7;
  localparam int OP_W = 33;
  localparam int PROD_W = 2 * OP_W;

  localparam logic CFG_STAGE_COUNT = 1'b0;
  localparam logic CFG_TRIM = 1'b1;

  localparam logic signed [OP_W-1:0] Q_HALF    = 33'sd134217728;
  localparam logic signed [OP_W-1:0] CLAMP_LIM = 33'sd67108864;
  localparam logic signed [OP_W-1:0] RAD_TURN  = 33'sd683565276;
  localparam logic signed [OP_W-1:0] SN_C1     = 33'sd1686629713;
  localparam logic signed [OP_W-1:0] SN_C3     = 33'sd693598668;
  localparam logic signed [OP_W-1:0] SN_C5     = 33'sd85569306;
  localparam logic signed [OP_W-1:0] SN_C7     = 33'sd5026995;
  localparam logic signed [OP_W-1:0] SN_C9     = 33'sd172272;
  localparam logic signed [OP_W-1:0] SN_ONE    = 33'sd1073741824;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } store_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    else if (x < lo) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage

// ----- sv/sbt_mul.sv -----
// sbt_mul: shared signed multiplier with registered product
// depends on sbt_pkg for operand widths
module sbt_mul (
  input  logic                                  clk,
  input  logic signed [sbt_pkg::OP_W-1:0]       op_a,
  input  logic signed [sbt_pkg::OP_W-1:0]       op_b,
  output logic signed [sbt_pkg::PROD_W-1:0]     prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ----- sv/sbt_store.sv -----
// sbt_store: per-stage state memory with registered read and reset valid bits
// depends on sbt_pkg for the request struct
module sbt_store #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  sbt_pkg::store_req_t req,
  output logic signed [31:0]  rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [31:0]      rword;
  logic             rvld;
  logic [AW-1:0]    a;

  assign a = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[a] <= req.wdata;
    end
    rword <= mem[a];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (req.we) vld[a] <= 1'b1;
      rvld <= vld[a];
    end
  end

  assign rdata = rvld ? rword : 32'sd0;

endmodule

// ----- sv/sub_bass_tightener.sv -----
// Sub-bass tightener: one stereo frame per beat. Each channel is trimmed and run through
// stage_count nonlinear stages (zero counts as one, capped at MAX_STAGES) on one shared
// 33x33 multiplier, which is reused nine times per stage. in_stall is high while a frame
// is in work; a finished frame waits in the output register while the next one is taken
// in, and that next frame holds in S_FIN until the output register is free.
// depends on sbt_pkg, sbt_mul, sbt_store
module sub_bass_tightener #(
  parameter int MAX_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbt_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sbt_pkg::out_t       out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data
);

  localparam int DEPTH = 2 * MAX_STAGES;
  localparam int CW = $clog2(MAX_STAGES + 1);
  localparam int OW = sbt_pkg::OP_W;
  localparam int SW = sbt_pkg::SAMPLE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIM, S_V0, S_RD, S_ANG, S_U, S_C9, S_C7, S_C5, S_C3, S_C1,
    S_SN, S_NV, S_WR, S_FIN
  } state_t;

  state_t state;
  logic [4:0]  stage_count;
  logic [23:0] trim;
  logic signed [31:0] dry_l, dry_r, v;
  logic signed [31:0] s;
  logic [31:0] scale;
  logic [30:0] u, u2;
  logic [1:0]  quad;
  logic [CW-1:0] k, n;
  logic        ch;
  logic signed [SW-1:0] res_l;

  logic signed [OW-1:0] op_a, op_b;
  logic signed [sbt_pkg::PROD_W-1:0] prod;
  logic signed [31:0] rdata;
  sbt_pkg::store_req_t st_req;

  sbt_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(prod));
  sbt_store #(.DEPTH(DEPTH)) u_store (.clk(clk), .rst(rst), .req(st_req), .rdata(rdata));

  // combinational datapath
  logic signed [31:0] dry, v_trim, ang, v_new, st_new;
  logic [31:0]  mag, scale_next, phase;
  logic [30:0]  u_next, u2_next;
  logic signed [sbt_pkg::PROD_W-1:0] p30, p28, p24;
  logic signed [OW-1:0] acc_c7, acc_c5, acc_c3, acc_c1, t_sn, t_cl, sn;
  logic signed [OW-1:0] vf, vc, y, y_sh;
  logic signed [SW-1:0] y_sat;
  logic [6:0] sc_wide;
  logic [CW-1:0] n_eff;
  logic can_out;
  logic out_load;

  assign dry = ch ? dry_r : dry_l;
  assign p30 = prod >>> 30;
  assign p28 = prod >>> 28;
  assign p24 = prod >>> 24;
  assign v_trim = sbt_pkg::sat32(p24[39:0]);
  assign mag = v[31] ? 32'(-v) : 32'(v);
  assign scale_next = 32'(sbt_pkg::Q_HALF) + (mag >> 1);
  assign ang = sbt_pkg::sat32(40'(rdata) - 40'(v));
  assign phase = prod[59:28];
  assign u_next = phase[30] ? (31'd1073741824 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  assign u2_next = prod[60:30];
  assign acc_c7 = sbt_pkg::SN_C7 - p30[OW-1:0];
  assign acc_c5 = sbt_pkg::SN_C5 - p30[OW-1:0];
  assign acc_c3 = sbt_pkg::SN_C3 - p30[OW-1:0];
  assign acc_c1 = sbt_pkg::SN_C1 - p30[OW-1:0];
  assign t_sn = p30[OW-1:0];
  assign v_new = sbt_pkg::sat32(40'(s) + p28[39:0]);
  assign st_new = sbt_pkg::sat32(p28[39:0]);

  always_comb begin
    if (t_sn > sbt_pkg::SN_ONE) t_cl = sbt_pkg::SN_ONE;
    else if (t_sn < 0) t_cl = '0;
    else t_cl = t_sn;
    sn = (quad[1] ? -t_cl : t_cl) >>> 2;
  end

  // final correction and output saturation
  always_comb begin
    vf = n[0] ? -OW'(v) : OW'(v);
    if (vf > sbt_pkg::CLAMP_LIM) vc = sbt_pkg::CLAMP_LIM;
    else if (vf < -sbt_pkg::CLAMP_LIM) vc = -sbt_pkg::CLAMP_LIM;
    else vc = vf;
    y = OW'(dry) - (vc <<< 4);
    y_sh = y >>> sbt_pkg::IN_SHIFT;
    if (y_sh > OW'(2 ** (SW - 1) - 1)) y_sat = {1'b0, {(SW - 1){1'b1}}};
    else if (y_sh < -OW'(2 ** (SW - 1))) y_sat = {1'b1, {(SW - 1){1'b0}}};
    else y_sat = y_sh[SW-1:0];
  end

  always_comb begin
    sc_wide = (stage_count == 5'd0) ? 7'd1 : {2'b0, stage_count};
    if (sc_wide > 7'(MAX_STAGES)) n_eff = CW'(MAX_STAGES);
    else n_eff = CW'(sc_wide);
  end

  assign can_out = !out_valid || !out_stall;
  assign out_load = (state == S_FIN) && ch && can_out;

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_TRIM: begin op_a = OW'(dry); op_b = OW'({1'b0, trim}); end
      S_ANG:  begin op_a = OW'(ang); op_b = sbt_pkg::RAD_TURN; end
      S_U:    begin op_a = OW'({1'b0, u_next}); op_b = OW'({1'b0, u_next}); end
      S_C9:   begin op_a = OW'({1'b0, u2_next}); op_b = sbt_pkg::SN_C9; end
      S_C7:   begin op_a = OW'({1'b0, u2}); op_b = acc_c7; end
      S_C5:   begin op_a = OW'({1'b0, u2}); op_b = acc_c5; end
      S_C3:   begin op_a = OW'({1'b0, u2}); op_b = acc_c3; end
      S_C1:   begin op_a = OW'({1'b0, u}); op_b = acc_c1; end
      S_SN:   begin op_a = sn; op_b = OW'({1'b0, scale}); end
      S_NV:   begin op_a = OW'(v_new); op_b = OW'({1'b0, scale}); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    st_req.addr  = sbt_pkg::ADDR_W'({k, ch});
    st_req.we    = (state == S_WR);
    st_req.wdata = st_new;
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stage_count <= 5'd1;
      trim        <= '0;
      out_valid   <= 1'b0;
      k           <= '0;
      ch          <= 1'b0;
      n           <= CW'(1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sbt_pkg::CFG_STAGE_COUNT: stage_count <= cfg_data[4:0];
          sbt_pkg::CFG_TRIM:        trim <= cfg_data;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dry_l <= 32'(in_data.left_sample) <<< sbt_pkg::IN_SHIFT;
            dry_r <= 32'(in_data.right_sample) <<< sbt_pkg::IN_SHIFT;
            n     <= n_eff;
            ch    <= 1'b0;
            state <= S_TRIM;
          end
        end
        S_TRIM: state <= S_V0;
        S_V0: begin
          v     <= v_trim;
          k     <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_ANG;
        S_ANG: begin
          s     <= rdata;
          scale <= scale_next;
          state <= S_U;
        end
        S_U: begin
          u     <= u_next;
          quad  <= phase[31:30];
          state <= S_C9;
        end
        S_C9: begin u2 <= u2_next; state <= S_C7; end
        S_C7: state <= S_C5;
        S_C5: state <= S_C3;
        S_C3: state <= S_C1;
        S_C1: state <= S_SN;
        S_SN: state <= S_NV;
        S_NV: begin v <= v_new; state <= S_WR; end
        S_WR: begin
          k     <= k + CW'(1);
          state <= (k + CW'(1) == n) ? S_FIN : S_RD;
        end
        S_FIN: begin
          if (!ch) begin
            res_l <= y_sat;
            ch    <= 1'b1;
            state <= S_TRIM;
          end else if (can_out) begin
            out_data.left_out  <= res_l;
            out_data.right_out <= y_sat;
            ch    <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a beat but did not go busy");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    st_req.we |-> (k < n))
    else $error("stage store written past the stages in use");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && ch && can_out |=> out_valid && state == S_IDLE)
    else $error("finished frame not presented");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && state != S_FIN |=> out_valid && $stable(out_data))
    else $error("waiting result lost");

endmodule
